[sv/bgap_pkg.sv]
`timescale 1ns / 1ps

package bgap_pkg;

	localparam int unsigned BitsPerByte = 8;
	localparam int unsigned IdxW        = $clog2(BitsPerByte);
	localparam int unsigned PosW        = 8;
	localparam int unsigned BposW       = PosW - IdxW;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} bgap_state_t;

	// control from the sequencer to the shared subtract unit
	typedef struct packed {
		logic            set_origin;
		logic            emit;
		logic            last;
		logic [PosW-1:0] pos;
	} bgap_ctl_t;

	// index of the lowest set bit, or 8 for a zero byte
	function automatic logic [IdxW:0] lowest_set(input logic [BitsPerByte-1:0] v);
		logic [IdxW:0] r;
		r = (IdxW+1)'(BitsPerByte);
		for (int i = BitsPerByte - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = (IdxW+1)'(i);
			end
		end
		return r;
	endfunction

endpackage

[sv/bitmap_to_gap_encoder.sv]
`timescale 1ns / 1ps
// Path: a data byte is held in the mask register, and each of its gaps is registered in the output register.
// Throughput: a data byte with set bits stalls the input while its gaps leave; origin
// bytes and zero bytes do not stall it. One gap leaves per cycle while out_stall is low, set by the
// single shared subtractor and the one-entry output register.
// Reset (arst_n low, asynchronous): idle, next byte is a stream origin, positions zero.

module bitmap_to_gap_encoder
	import bgap_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [BitsPerByte-1:0] bitmap_byte,
	input  logic                   stream_start,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [PosW-1:0]        gap,
	output logic                   last_in_byte
);

	bgap_ctl_t       ctl;
	logic [PosW-1:0] gap_next;
	logic            out_free;
	logic            out_valid_q;
	logic [PosW-1:0] gap_q;
	logic            last_q;

	// output slot free when empty or being taken
	assign out_free = !out_valid_q || !out_stall;

	bgap_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.bitmap_byte  (bitmap_byte),
		.stream_start (stream_start),
		.out_free     (out_free),
		.ctl          (ctl)
	);

	bgap_diff u_diff (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.gap_next (gap_next)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= ctl.emit;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			gap_q  <= gap_next;
			last_q <= ctl.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign gap          = gap_q;
	assign last_in_byte = last_q;

endmodule

[sv/bgap_seq.sv]
`timescale 1ns / 1ps

module bgap_seq
	import bgap_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [BitsPerByte-1:0] bitmap_byte,
	input  logic                   stream_start,
	input  logic                   out_free,
	output bgap_ctl_t              ctl
);

	bgap_state_t            state_q;
	logic [BitsPerByte-1:0] mask_q;
	logic [BposW-1:0]       base_q;
	logic [BposW-1:0]       bpos_q;
	logic                   pending_q;

	logic                   accept;
	logic                   origin;
	logic [IdxW:0]          in_low;
	logic [IdxW:0]          mask_low;
	logic [IdxW-1:0]        lsb_idx;
	logic [BitsPerByte-1:0] rest;

	// input handshake and lowest set bit of the remaining mask
	always_comb begin
		in_stall = (state_q != S_IDLE);
		accept   = in_valid && (state_q == S_IDLE);
		origin   = stream_start || pending_q;
		in_low   = lowest_set(bitmap_byte);
		mask_low = lowest_set(mask_q);
		lsb_idx  = mask_low[IdxW-1:0];
		rest     = mask_q & ~(BitsPerByte'(1) << lsb_idx);
	end

	// control word for the shared unit
	always_comb begin
		ctl = '0;
		if (accept && origin) begin
			ctl.set_origin = 1'b1;
			ctl.pos        = PosW'(in_low);
		end else if ((state_q == S_SCAN) && out_free) begin
			ctl.emit = 1'b1;
			ctl.last = (rest == '0);
			ctl.pos  = {base_q, lsb_idx};
		end
	end

	// sequencer state and position bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			bpos_q    <= '0;
			pending_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (origin) begin
							bpos_q    <= BposW'(1);
							pending_q <= 1'b0;
						end else begin
							bpos_q <= bpos_q + BposW'(1);
							if (bitmap_byte != '0) begin
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					if (out_free && (rest == '0)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// remaining bits of the byte under scan
	always_ff @(posedge clk) begin
		if (accept && !origin) begin
			mask_q <= bitmap_byte;
			base_q <= bpos_q;
		end else if ((state_q == S_SCAN) && out_free) begin
			mask_q <= rest;
		end
	end

endmodule

[sv/bgap_diff.sv]
`timescale 1ns / 1ps

module bgap_diff
	import bgap_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  bgap_ctl_t       ctl,
	output logic [PosW-1:0] gap_next
);

	logic [PosW-1:0] last_pos_q;

	// shared subtractor, wraps modulo 256
	assign gap_next = ctl.pos - last_pos_q;

	// previous set-bit position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q <= '0;
		end else if (ctl.set_origin || ctl.emit) begin
			last_pos_q <= ctl.pos;
		end
	end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
	import bgap_pkg::*;

	localparam int unsigned IdleLimit  = 4000;
	localparam int unsigned DrainWait  = 30;
	localparam int unsigned RandItems  = 108;

	// one expected gap result
	typedef struct packed {
		logic [PosW-1:0] gap;
		logic            last;
	} gap_result_t;

	logic                   clk          = 1'b0;
	logic                   arst_n;
	logic                   in_valid     = 1'b0;
	logic                   in_stall;
	logic [BitsPerByte-1:0] bitmap_byte  = '0;
	logic                   stream_start = 1'b0;
	logic                   out_valid;
	logic                   out_stall    = 1'b0;
	logic [PosW-1:0]        gap;
	logic                   last_in_byte;

	// predictor state
	logic [PosW-1:0]  prev_pos;
	logic [BposW-1:0] byte_idx;
	logic             origin_due;

	gap_result_t gap_q[$];
	int unsigned mismatch_cnt = 0;
	int unsigned idle_cycles  = 0;

	// idling controls
	int unsigned gap_max    = 0;
	int unsigned burst_max  = 0;
	int unsigned burst_left = 0;
	int unsigned stall_pct  = 0;
	int unsigned stall_run  = 0;

	bitmap_to_gap_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.bitmap_byte  (bitmap_byte),
		.stream_start (stream_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.gap          (gap),
		.last_in_byte (last_in_byte)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// work out the gaps one accepted byte produces
	task automatic predict_gaps(input logic [BitsPerByte-1:0] b, input logic s);
		logic [PosW-1:0] pos;
		logic [PosW-1:0] base;
		int              top;
		int              low;
		gap_result_t     r;
		if (s || origin_due) begin
			low = BitsPerByte;
			for (int i = BitsPerByte - 1; i >= 0; i--) begin
				if (b[i]) begin
					low = i;
				end
			end
			prev_pos   = PosW'(low);
			byte_idx   = BposW'(1);
			origin_due = 1'b0;
			return;
		end
		top = 0;
		for (int i = 0; i < BitsPerByte; i++) begin
			if (b[i]) begin
				top = i;
			end
		end
		base = {byte_idx, IdxW'(0)};
		for (int i = 0; i < BitsPerByte; i++) begin
			if (b[i]) begin
				pos      = base + PosW'(i);
				r.gap    = pos - prev_pos;
				r.last   = (i == top);
				prev_pos = pos;
				gap_q.push_back(r);
			end
		end
		byte_idx = byte_idx + BposW'(1);
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatch_cnt++;
	endtask

	task automatic set_idling(input int unsigned gmax, input int unsigned bmax,
			input int unsigned spct, input int unsigned srun);
		gap_max    = gmax;
		burst_max  = bmax;
		burst_left = 0;
		stall_pct  = spct;
		stall_run  = srun;
	endtask

	// drive one byte, wait for its transfer, then idle per the burst pattern
	task automatic send_byte(input logic [BitsPerByte-1:0] b, input logic s);
		bitmap_byte  <= b;
		stream_start <= s;
		in_valid     <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_gaps(b, s);
		if (burst_left > 0) begin
			burst_left--;
		end else if (gap_max > 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, gap_max)) @(posedge clk);
			burst_left = $urandom_range(0, burst_max);
		end
	endtask

	// byte content of a chosen density
	function automatic logic [BitsPerByte-1:0] pick_byte(input int unsigned kind);
		logic [BitsPerByte-1:0] v;
		case (kind)
			0: v = '0;
			1: v = BitsPerByte'(1) << $urandom_range(0, BitsPerByte - 1);
			2: v = BitsPerByte'($urandom);
			3: v = BitsPerByte'($urandom) | BitsPerByte'($urandom);
			default: v = '1;
		endcase
		return v;
	endfunction

	// output checker and receiver stall pattern
	always @(posedge clk) begin
		gap_result_t r;
		if (arst_n && out_valid && !out_stall) begin
			if (gap_q.size() == 0) begin
				report_mismatch($sformatf("unexpected gap %0d last %0b", gap, last_in_byte));
			end else begin
				r = gap_q.pop_front();
				if (gap !== r.gap) begin
					report_mismatch($sformatf("gap %0d, expected %0d", gap, r.gap));
				end
				if (last_in_byte !== r.last) begin
					report_mismatch($sformatf("last_in_byte %0b, expected %0b",
						last_in_byte, r.last));
				end
			end
		end
		if (stall_run > 0) begin
			stall_run--;
			out_stall <= 1'b1;
		end else if ($urandom_range(99) < stall_pct) begin
			stall_run = $urandom_range(0, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("timeout: no transfer for %0d cycles", IdleLimit);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// first byte after reset is an origin even without stream_start
	task automatic test_first_byte();
		send_byte(8'b1010_0100, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b0);
	endtask

	// extreme bytes as origin and as data
	task automatic test_extremes();
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
	endtask

	// restart in the middle of a stream drops the old position
	task automatic test_restart();
		send_byte(8'h10, 1'b1);
		send_byte(8'h81, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7E, 1'b1);
		send_byte(8'h7E, 1'b1);
		send_byte(8'h02, 1'b0);
	endtask

	// byte index wraps after 32 bytes, giving a zero gap
	task automatic test_wrap();
		send_byte(8'h01, 1'b1);
		repeat (31) send_byte(8'h00, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h81, 1'b0);
	endtask

	// random streams, mostly well formed, with stray restarts
	task automatic test_random(input int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		int unsigned kind;
		sent = 0;
		while (sent < n_items) begin
			len  = ($urandom_range(7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 10);
			kind = $urandom_range(0, 4);
			send_byte(pick_byte($urandom_range(0, 4)), $urandom_range(9) != 0);
			sent++;
			for (int unsigned k = 0; k < len && sent < n_items; k++) begin
				if ($urandom_range(3) == 0) begin
					kind = $urandom_range(0, 4);
				end
				send_byte(pick_byte(kind), $urandom_range(24) == 0);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n     <= 1'b0;
		prev_pos   = '0;
		byte_idx   = '0;
		origin_due = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(0, 0, 0, 0);
		test_first_byte();
		set_idling(3, 2, 30, 0);
		test_extremes();
		set_idling(1, 4, 10, 0);
		test_restart();
		set_idling(0, 0, 0, 0);
		test_wrap();

		// random part in phases of differing pressure
		set_idling(0, 0, 0, 0);
		test_random(RandItems / 4);
		set_idling(6, 3, 50, 0);
		test_random(RandItems / 4);
		set_idling(2, 8, 15, 0);
		test_random(RandItems / 4);
		set_idling(0, 0, 70, 0);
		test_random(RandItems / 4);

		in_valid <= 1'b0;
		while (gap_q.size() != 0) @(posedge clk);
		repeat (DrainWait) @(posedge clk);

		if (mismatch_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
